### hw/rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle plane classifier
// Side codes, count limits, register indexes and lane control types.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int MAX_TRIS  = 65536;
  localparam int CNT_W     = 18;
  localparam int COORD_W   = 32;
  localparam int NORM_W    = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = NORM_W + DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int LIMIT_INT = (2 * MAX_TRIS > CNT_MAX) ? CNT_MAX : 2 * MAX_TRIS;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = LIMIT_INT[CNT_W-1:0];

  // vertex side codes
  localparam logic [1:0] SIDE_FRONT = 2'd0;
  localparam logic [1:0] SIDE_BACK  = 2'd1;
  localparam logic [1:0] SIDE_ON    = 2'd2;

  // triangle class codes
  localparam logic [1:0] TRI_FRONT   = 2'd0;
  localparam logic [1:0] TRI_BACK    = 2'd1;
  localparam logic [1:0] TRI_THROUGH = 2'd2;
  localparam logic [1:0] TRI_SPLIT   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [NORM_W-1:0] x;
    logic [NORM_W-1:0] y;
    logic [NORM_W-1:0] z;
  } norm_t;

  // per-stage load enables for the lane pipeline
  typedef struct packed {
    logic diff;
    logic prod;
    logic sum;
  } lane_en_t;

endpackage

### hw/rtl/tpc_lane.sv
// ----------------------------------------------------------------------------
// tpc_lane: one vertex lane
// Three-stage signed dot product of normal with (vertex - origin); emits side.
// ----------------------------------------------------------------------------
module tpc_lane (
  input  logic             clk,
  input  tpc_pkg::lane_en_t en,
  input  tpc_pkg::vec_t     vertex,
  input  tpc_pkg::vec_t     origin,
  input  tpc_pkg::norm_t    normal,
  output logic [1:0]        side
);

  logic signed [tpc_pkg::DIFF_W-1:0] dx, dy, dz;
  logic signed [tpc_pkg::PROD_W-1:0] px, py, pz;
  logic signed [tpc_pkg::DOT_W-1:0]  dot;

  always_ff @(posedge clk) begin
    if (en.diff) begin
      dx <= $signed({vertex.x[tpc_pkg::COORD_W-1], vertex.x})
          - $signed({origin.x[tpc_pkg::COORD_W-1], origin.x});
      dy <= $signed({vertex.y[tpc_pkg::COORD_W-1], vertex.y})
          - $signed({origin.y[tpc_pkg::COORD_W-1], origin.y});
      dz <= $signed({vertex.z[tpc_pkg::COORD_W-1], vertex.z})
          - $signed({origin.z[tpc_pkg::COORD_W-1], origin.z});
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      px <= $signed(normal.x) * dx;
      py <= $signed(normal.y) * dy;
      pz <= $signed(normal.z) * dz;
    end
  end

  assign dot = {{2{px[tpc_pkg::PROD_W-1]}}, px}
             + {{2{py[tpc_pkg::PROD_W-1]}}, py}
             + {{2{pz[tpc_pkg::PROD_W-1]}}, pz};

  always_ff @(posedge clk) begin
    if (en.sum) begin
      if (dot[tpc_pkg::DOT_W-1]) begin
        side <= tpc_pkg::SIDE_BACK;
      end else if (dot == '0) begin
        side <= tpc_pkg::SIDE_ON;
      end else begin
        side <= tpc_pkg::SIDE_FRONT;
      end
    end
  end

endmodule

### hw/rtl/tpc_merge.sv
// ----------------------------------------------------------------------------
// tpc_merge: merge stage
// Combines the three vertex sides into a class and keeps the saturating counts.
// ----------------------------------------------------------------------------
module tpc_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ld,
  input  logic                      first,
  input  logic [2:0][1:0]           sides,
  output logic [1:0]                tri_side,
  output logic [2:0][1:0]           sides_out,
  output logic [tpc_pkg::CNT_W-1:0] front_count,
  output logic [tpc_pkg::CNT_W-1:0] back_count
);

  logic [tpc_pkg::CNT_W-1:0] cf, cb;
  logic [tpc_pkg::CNT_W-1:0] front_count_next, back_count_next;
  logic [tpc_pkg::CNT_W:0]   sum_f, sum_b;
  logic [1:0]                nf, nb, non;
  logic [1:0]                inc_f, inc_b;
  logic [1:0]                tri_c;

  always_comb begin
    nf  = 2'd0;
    nb  = 2'd0;
    non = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (sides[i] == tpc_pkg::SIDE_FRONT) begin
        nf = nf + 2'd1;
      end else if (sides[i] == tpc_pkg::SIDE_BACK) begin
        nb = nb + 2'd1;
      end else begin
        non = non + 2'd1;
      end
    end
  end

  assign cf = first ? '0 : front_count;
  assign cb = first ? '0 : back_count;

  always_comb begin
    if (non == 2'd3) begin
      // coplanar: goes to the smaller side, tie goes back
      tri_c = (cf < cb) ? tpc_pkg::TRI_FRONT : tpc_pkg::TRI_BACK;
    end else if (nb == 2'd0) begin
      tri_c = tpc_pkg::TRI_FRONT;
    end else if (nf == 2'd0) begin
      tri_c = tpc_pkg::TRI_BACK;
    end else if (non == 2'd1) begin
      tri_c = tpc_pkg::TRI_THROUGH;
    end else begin
      tri_c = tpc_pkg::TRI_SPLIT;
    end
  end

  always_comb begin
    case (tri_c)
      tpc_pkg::TRI_FRONT: begin
        inc_f = 2'd1;
        inc_b = 2'd0;
      end
      tpc_pkg::TRI_BACK: begin
        inc_f = 2'd0;
        inc_b = 2'd1;
      end
      tpc_pkg::TRI_THROUGH: begin
        inc_f = 2'd1;
        inc_b = 2'd1;
      end
      default: begin
        // split: majority side takes two
        inc_f = (nf >= 2'd2) ? 2'd2 : 2'd1;
        inc_b = (nf >= 2'd2) ? 2'd1 : 2'd2;
      end
    endcase
  end

  assign sum_f = {1'b0, cf} + {{(tpc_pkg::CNT_W-1){1'b0}}, inc_f};
  assign sum_b = {1'b0, cb} + {{(tpc_pkg::CNT_W-1){1'b0}}, inc_b};

  assign front_count_next = (sum_f > {1'b0, tpc_pkg::COUNT_LIMIT}) ? tpc_pkg::COUNT_LIMIT
                                                                 : sum_f[tpc_pkg::CNT_W-1:0];
  assign back_count_next  = (sum_b > {1'b0, tpc_pkg::COUNT_LIMIT}) ? tpc_pkg::COUNT_LIMIT
                                                                 : sum_b[tpc_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      front_count <= '0;
      back_count  <= '0;
    end else if (ld) begin
      front_count <= front_count_next;
      back_count  <= back_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      tri_side  <= tri_c;
      sides_out <= sides;
    end
  end

endmodule

### hw/rtl/triangle_plane_classifier_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_classifier_unit: triangle vs. plane side classifier
// Path from accepted input word to output word: diff, product and sum/sign
//   registers in each vertex lane, then the merge/count register.
// Throughput: one word per cycle while out_stall is low; each stage has its
//   own valid bit and bubbles collapse, so input stalls only when all are full.
// Reset (rst, synchronous): clears valid bits and counts; normal = (0,0,32767),
//   origin = 0.
// ----------------------------------------------------------------------------
module triangle_plane_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_of_scene,
  input  logic [31:0] v0_x,
  input  logic [31:0] v0_y,
  input  logic [31:0] v0_z,
  input  logic [31:0] v1_x,
  input  logic [31:0] v1_y,
  input  logic [31:0] v1_z,
  input  logic [31:0] v2_x,
  input  logic [31:0] v2_y,
  input  logic [31:0] v2_z,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  tri_side,
  output logic [1:0]  side_v0,
  output logic [1:0]  side_v1,
  output logic [1:0]  side_v2,
  output logic [17:0] front_total,
  output logic [17:0] back_total
);

  // plane registers; the user must write them only while idle, not enforced here
  tpc_pkg::norm_t normal;
  tpc_pkg::vec_t  origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal <= '{x: 16'd0, y: 16'd0, z: 16'd32767};
      origin <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpc_pkg::REG_NORMAL_X: normal.x <= cfg_data[15:0];
        tpc_pkg::REG_NORMAL_Y: normal.y <= cfg_data[15:0];
        tpc_pkg::REG_NORMAL_Z: normal.z <= cfg_data[15:0];
        tpc_pkg::REG_ORIGIN_X: origin.x <= cfg_data;
        tpc_pkg::REG_ORIGIN_Y: origin.y <= cfg_data;
        tpc_pkg::REG_ORIGIN_Z: origin.z <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // Stage valids: 1 diff, 2 product, 3 sign, o merge/output.
  // A stage loads when it is empty or its contents move on this cycle.
  logic v1, v2, v3, vo;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic f1, f2, f3;

  assign rdy_o = !vo || !out_stall;
  assign rdy3  = !v3 || rdy_o;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;

  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1)  v1 <= in_valid;
      if (rdy2)  v2 <= v1;
      if (rdy3)  v3 <= v2;
      if (rdy_o) vo <= v3;
    end
  end

  // scene-start flag rides alongside the lanes
  always_ff @(posedge clk) begin
    if (rdy1) f1 <= first_of_scene;
    if (rdy2) f2 <= f1;
    if (rdy3) f3 <= f2;
  end

  tpc_pkg::lane_en_t lane_en;
  assign lane_en = '{diff: rdy1, prod: rdy2, sum: rdy3};

  tpc_pkg::vec_t    vtx [3];
  logic [2:0][1:0]  sides;
  logic [2:0][1:0]  sides_out;

  assign vtx[0] = '{x: v0_x, y: v0_y, z: v0_z};
  assign vtx[1] = '{x: v1_x, y: v1_y, z: v1_z};
  assign vtx[2] = '{x: v2_x, y: v2_y, z: v2_z};

  // one lane per vertex
  for (genvar g = 0; g < 3; g++) begin : g_lane
    tpc_lane u_lane (
      .clk    (clk),
      .en     (lane_en),
      .vertex (vtx[g]),
      .origin (origin),
      .normal (normal),
      .side   (sides[g])
    );
  end

  // merge: class, counts and the output register; counts move only on a word
  tpc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ld          (v3 && rdy_o),
    .first       (f3),
    .sides       (sides),
    .tri_side    (tri_side),
    .sides_out   (sides_out),
    .front_count (front_total),
    .back_count  (back_total)
  );

  assign out_valid = vo;
  assign side_v0   = sides_out[0];
  assign side_v1   = sides_out[1];
  assign side_v2   = sides_out[2];

endmodule
